[hw/rtl/svpwm_pkg.sv]
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and coefficient tables of the SVPWM duty sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

  localparam int unsigned FRACTION_BITS     = 16;
  localparam int unsigned SAMPLES_PER_CYCLE = 48;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned SUM_W    = DUTY_W + 1;
  localparam int unsigned TOTAL_W  = DUTY_W + 2;
  localparam int unsigned COEF_W   = FRACTION_BITS;
  localparam int unsigned PROD_W   = COEF_W + DUTY_W;
  localparam int unsigned SAMPLE_W = 6;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned OFFSET_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam longint unsigned DEC_SCALE = 10000;
  localparam longint unsigned DEC_HALF  = 5000;

  typedef logic [DUTY_W-1:0]    duty_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [COEF_W-1:0]    coef_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [SECTOR_W-1:0]  sector_t;
  typedef logic [OFFSET_W-1:0]  offset_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam sample_t SAMPLE_LAST  = sample_t'(SAMPLES_PER_CYCLE - 1);
  localparam sample_t SAMPLE_COUNT = sample_t'(SAMPLES_PER_CYCLE);

  localparam duty_t PERIOD_RESET    = duty_t'(2083);
  localparam duty_t AMPLITUDE_RESET = duty_t'(208);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_AMPLITUDE = 2'd1
  } cfg_reg_t;

  typedef enum logic [SECTOR_W-1:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_code_t;

  // Per-phase offsets and the shared half zero-vector time.
  typedef struct packed {
    sum_t  x_a;
    sum_t  x_b;
    sum_t  x_c;
    duty_t half;
  } sector_map_t;

  // Coefficient in units of 1e-4, rounded to nearest with halves up.
  function automatic coef_t to_fixed(input longint unsigned dec);
    longint unsigned scaled;
    scaled = ((dec << FRACTION_BITS) + DEC_HALF) / DEC_SCALE;
    return coef_t'(scaled);
  endfunction

  localparam coef_t FWD_COEF [8] = '{
    to_fixed(0),    to_fixed(1305), to_fixed(2588), to_fixed(3827),
    to_fixed(5000), to_fixed(6088), to_fixed(7070), to_fixed(7934)
  };

  localparam coef_t REV_COEF [8] = '{
    to_fixed(8660), to_fixed(7934), to_fixed(7070), to_fixed(6088),
    to_fixed(5000), to_fixed(3827), to_fixed(2588), to_fixed(1305)
  };

endpackage

`default_nettype wire

[hw/rtl/svpwm_sector_map.sv]
// ----------------------------------------------------------------------------
// svpwm_sector_map
// Zero-vector time and sector-dependent phase offsets from Tl and Tr.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sector_map (
  input  wire svpwm_pkg::sector_t     sector,
  input  wire svpwm_pkg::duty_t       tl,
  input  wire svpwm_pkg::duty_t       tr,
  input  wire svpwm_pkg::duty_t       period,
  output svpwm_pkg::sector_map_t      map
);
  import svpwm_pkg::*;

  sum_t  sum;
  sum_t  t0_diff;
  duty_t t0;

  always_comb begin
    sum     = sum_t'(tl) + sum_t'(tr);
    t0_diff = sum_t'(period) - sum;
    // Saturate the zero-vector time at zero.
    t0      = (sum > sum_t'(period)) ? '0 : t0_diff[DUTY_W-1:0];
    map.half = t0 >> 1;
    case (sector)
      SECTOR_0: begin
        map.x_a = sum;           map.x_b = sum_t'(tl);    map.x_c = '0;
      end
      SECTOR_1: begin
        map.x_a = sum_t'(tr);    map.x_b = sum;           map.x_c = '0;
      end
      SECTOR_2: begin
        map.x_a = '0;            map.x_b = sum;           map.x_c = sum_t'(tl);
      end
      SECTOR_3: begin
        map.x_a = '0;            map.x_b = sum_t'(tr);    map.x_c = sum;
      end
      SECTOR_4: begin
        map.x_a = sum_t'(tl);    map.x_b = '0;            map.x_c = sum;
      end
      default: begin
        map.x_a = sum;           map.x_b = '0;            map.x_c = sum_t'(tr);
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/svpwm_duty_sequencer.sv]
// ----------------------------------------------------------------------------
// svpwm_duty_sequencer
// Seven-segment space vector PWM compare-value generator, one result per tick.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+-------------------------------
//  input    | in        | in_valid / in_stall   | sync
//  result   | out       | out_valid / out_stall | duty_a, duty_b, duty_c,
//           |           |                       | sector_out, sample_out
//  config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Four-stage pipeline: each tick passes the stages in order from transfer to
//  result (index and coefficient lookup, the two multipliers, sector mapping,
//  final subtract). A new tick is taken every cycle while the pipe flows.
//  A stalled result holds in the output stage; earlier stages keep filling
//  bubbles, so in_stall rises only when all four stages are full.
//  Synchronous reset empties the pipe, zeroes the sample index and restores
//  period = 2083, amplitude = 208.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_duty_sequencer (
  input  wire                       clk,
  input  wire                       rst,
  // Tick input
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       sync,
  // Result output
  output logic                      out_valid,
  input  wire                       out_stall,
  output svpwm_pkg::duty_t          duty_a,
  output svpwm_pkg::duty_t          duty_b,
  output svpwm_pkg::duty_t          duty_c,
  output svpwm_pkg::sector_t        sector_out,
  output svpwm_pkg::sample_t        sample_out,
  // Configuration writes
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire svpwm_pkg::cfg_idx_t  cfg_index,
  input  wire svpwm_pkg::duty_t     cfg_data
);
  import svpwm_pkg::*;

  // Configuration registers
  duty_t   period;
  duty_t   amplitude;

  // Sample index state
  sample_t sample_index;
  sample_t sample_index_next;
  sample_t k_in;

  // Stage valids and advance enables
  logic    v1, v2, v3, v4;
  logic    free1, free2, free3, free4;
  logic    in_accept;

  // Stage 1: index, sector, saturated amplitude, coefficients
  sample_t s1_k;
  sector_t s1_sector;
  duty_t   s1_amp;
  coef_t   s1_coef_f;
  coef_t   s1_coef_r;
  offset_t m_in;
  duty_t   amp_in;

  // Stage 2: Tl, Tr
  prod_t   prod_l;
  prod_t   prod_r;
  sample_t s2_k;
  sector_t s2_sector;
  duty_t   s2_tl;
  duty_t   s2_tr;

  // Stage 3: mapped offsets
  sector_map_t map;
  sector_map_t s3_map;
  sample_t     s3_k;
  sector_t     s3_sector;

  // Stage 4 arithmetic
  total_t  tot_a, tot_b, tot_c;
  total_t  dif_a, dif_b, dif_c;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, ignore unknown indexes.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_RESET;
      amplitude <= AMPLITUDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD:    period    <= cfg_data;
        REG_AMPLITUDE: amplitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow: a stage loads when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  assign free4     = !v4 || !out_stall;
  assign free3     = !v3 || free4;
  assign free2     = !v2 || free3;
  assign free1     = !v1 || free2;
  assign in_stall  = !free1;
  assign in_accept = in_valid && free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // Sample index: restart on sync, treat out-of-range as zero, wrap at 47.
  // --------------------------------------------------------------------------
  always_comb begin
    if (sync || (sample_index >= SAMPLE_COUNT)) begin
      k_in = '0;
    end else begin
      k_in = sample_index;
    end
    sample_index_next = (k_in == SAMPLE_LAST) ? '0 : k_in + sample_t'(1);
    m_in   = k_in[OFFSET_W-1:0];
    amp_in = (amplitude > period) ? period : amplitude;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (in_accept) begin
      sample_index <= sample_index_next;
    end
  end

  // Stage 1: register index, sector and looked-up coefficients.
  always_ff @(posedge clk) begin
    if (free1) begin
      s1_k      <= k_in;
      s1_sector <= sector_t'(k_in >> OFFSET_W);
      s1_amp    <= amp_in;
      s1_coef_f <= FWD_COEF[m_in];
      s1_coef_r <= REV_COEF[m_in];
    end
  end

  // Stage 2: scale both coefficients by the amplitude, floor the fraction.
  assign prod_l = prod_t'(s1_coef_f) * prod_t'(s1_amp);
  assign prod_r = prod_t'(s1_coef_r) * prod_t'(s1_amp);

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_k      <= s1_k;
      s2_sector <= s1_sector;
      s2_tl     <= prod_l[FRACTION_BITS +: DUTY_W];
      s2_tr     <= prod_r[FRACTION_BITS +: DUTY_W];
    end
  end

  // Stage 3: zero-vector time and per-phase offsets.
  svpwm_sector_map u_sector_map (
    .sector (s2_sector),
    .tl     (s2_tl),
    .tr     (s2_tr),
    .period (period),
    .map    (map)
  );

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_k      <= s2_k;
      s3_sector <= s2_sector;
      s3_map    <= map;
    end
  end

  // Stage 4: compare = period - (x + half), saturated at zero.
  always_comb begin
    tot_a = total_t'(s3_map.x_a) + total_t'(s3_map.half);
    tot_b = total_t'(s3_map.x_b) + total_t'(s3_map.half);
    tot_c = total_t'(s3_map.x_c) + total_t'(s3_map.half);
    dif_a = total_t'(period) - tot_a;
    dif_b = total_t'(period) - tot_b;
    dif_c = total_t'(period) - tot_c;
  end

  always_ff @(posedge clk) begin
    if (free4) begin
      duty_a     <= (tot_a > total_t'(period)) ? '0 : dif_a[DUTY_W-1:0];
      duty_b     <= (tot_b > total_t'(period)) ? '0 : dif_b[DUTY_W-1:0];
      duty_c     <= (tot_c > total_t'(period)) ? '0 : dif_c[DUTY_W-1:0];
      sector_out <= s3_sector;
      sample_out <= s3_k;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

[hw/rtl/svpwm_checker.sv]
// ----------------------------------------------------------------------------
// svpwm_checker
// Port-level checks of the SVPWM duty sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_checker (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       out_valid,
  input  wire                       out_stall,
  input  wire svpwm_pkg::duty_t     duty_a,
  input  wire svpwm_pkg::duty_t     duty_b,
  input  wire svpwm_pkg::duty_t     duty_c,
  input  wire svpwm_pkg::sector_t   sector_out,
  input  wire svpwm_pkg::sample_t   sample_out
);
  import svpwm_pkg::*;

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Sector always follows from the sample index.
  a_sector_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector_out == sector_t'(sample_out >> OFFSET_W)))
    else $error("sector does not match sample index");

  // Sample index stays in range.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out < SAMPLE_COUNT))
    else $error("sample index out of range");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty_a) && $stable(duty_b)
      && $stable(duty_c) && $stable(sample_out))
    else $error("stalled result changed");

endmodule

bind svpwm_duty_sequencer svpwm_checker u_svpwm_checker (.*);

`default_nettype wire
